// ----- hdl/ps2hid_pkg.sv -----
// Shared types, codes and lookup tables of the PS/2 set-2 to HID report converter.
package ps2hid_pkg;

  // Number of key slots that the block holds, and the fixed number in a report.
  localparam int unsigned DEFAULT_KEY_SLOTS = 6;
  localparam int unsigned REPORT_SLOTS      = 6;
  localparam int unsigned BASE_TABLE_SIZE   = 132;

  // PS/2 set-2 prefix and special bytes.
  localparam logic [7:0] CODE_SELF_TEST    = 8'hAA;
  localparam logic [7:0] CODE_PAUSE_PREFIX = 8'hE1;
  localparam logic [7:0] CODE_EXTENDED     = 8'hE0;
  localparam logic [7:0] CODE_RELEASE      = 8'hF0;
  localparam logic [7:0] CODE_PAUSE_FIRST  = 8'h14;
  localparam logic [7:0] CODE_PAUSE_SECOND = 8'h77;

  // HID usages with a special meaning.
  localparam logic [7:0] USAGE_NONE       = 8'h00;
  localparam logic [7:0] USAGE_PAUSE      = 8'h48;
  localparam logic [4:0] USAGE_MOD_PREFIX = 5'b11100;

  // One input transaction.
  typedef struct packed {
    logic       mode;
    logic [7:0] scan_byte;
  } ps2hid_in_t;

  // One report transaction.
  typedef struct packed {
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } ps2hid_out_t;

  // Key event passed from the scancode decoder to the key tracker.
  typedef struct packed {
    logic       flush;
    logic       key;
    logic       key_up;
    logic [7:0] usage;
  } ps2hid_event_t;

  // Base page: set-2 code to HID usage, codes 00..83.
  localparam logic [7:0] BASE_USAGE [BASE_TABLE_SIZE] = '{
    8'h00, 8'h42, 8'h00, 8'h3E, 8'h3C, 8'h3A, 8'h3B, 8'h45,
    8'h68, 8'h43, 8'h41, 8'h3F, 8'h3D, 8'h2B, 8'h35, 8'h67,
    8'h69, 8'hE2, 8'hE1, 8'h00, 8'hE0, 8'h14, 8'h1E, 8'h00,
    8'h6A, 8'h00, 8'h1D, 8'h16, 8'h04, 8'h1A, 8'h1F, 8'h00,
    8'h6B, 8'h06, 8'h1B, 8'h07, 8'h08, 8'h21, 8'h20, 8'h00,
    8'h6C, 8'h2C, 8'h19, 8'h09, 8'h17, 8'h15, 8'h22, 8'h00,
    8'h6D, 8'h11, 8'h05, 8'h0B, 8'h0A, 8'h1C, 8'h23, 8'h00,
    8'h6E, 8'h00, 8'h10, 8'h0D, 8'h18, 8'h24, 8'h25, 8'h00,
    8'h6F, 8'h36, 8'h0E, 8'h0C, 8'h12, 8'h27, 8'h26, 8'h00,
    8'h70, 8'h37, 8'h38, 8'h0F, 8'h33, 8'h13, 8'h2D, 8'h00,
    8'h71, 8'h00, 8'h34, 8'h00, 8'h2F, 8'h2E, 8'h00, 8'h72,
    8'h39, 8'hE5, 8'h28, 8'h30, 8'h00, 8'h32, 8'h00, 8'h73,
    8'h00, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2A, 8'h00,
    8'h00, 8'h59, 8'h00, 8'h5C, 8'h5F, 8'h00, 8'h00, 8'h00,
    8'h62, 8'h63, 8'h5A, 8'h5D, 8'h5E, 8'h60, 8'h29, 8'h53,
    8'h44, 8'h57, 8'h5B, 8'h56, 8'h55, 8'h61, 8'h47, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h40
  };

  // Base page lookup; codes past the table give no usage.
  function automatic logic [7:0] base_usage(input logic [7:0] code);
    logic [7:0] usage;
    usage = USAGE_NONE;
    if (code < 8'(BASE_TABLE_SIZE)) begin
      usage = BASE_USAGE[code];
    end
    return usage;
  endfunction

  // Extended page lookup, used after an E0 prefix.
  function automatic logic [7:0] extended_usage(input logic [7:0] code);
    logic [7:0] usage;
    case (code)
      8'h11:   usage = 8'hE6;
      8'h1F:   usage = 8'hE3;
      8'h14:   usage = 8'hE4;
      8'h27:   usage = 8'hE7;
      8'h4A:   usage = 8'h54;
      8'h5A:   usage = 8'h58;
      8'h69:   usage = 8'h4D;
      8'h6B:   usage = 8'h50;
      8'h6C:   usage = 8'h4A;
      8'h7C:   usage = 8'h46;
      8'h70:   usage = 8'h49;
      8'h71:   usage = 8'h4C;
      8'h72:   usage = 8'h51;
      8'h74:   usage = 8'h4F;
      8'h75:   usage = 8'h52;
      8'h7A:   usage = 8'h4E;
      8'h7D:   usage = 8'h4B;
      default: usage = USAGE_NONE;
    endcase
    return usage;
  endfunction

endpackage

// ----- hdl/ps2_scancode_to_hid_report.sv -----
// PS/2 set-2 scancode to HID boot-keyboard report converter.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one transaction per
// received byte: mode 0 carries a scancode byte, mode 1 flushes all held keys,
// modifiers and pending prefixes but the Pause prefix after a receiver overflow.
// Output channel (out_valid_o/out_ready_i/out_data_o) gives a full report,
// modifier byte and six key slots, each time a press or release changes a slot.
// Prefix bytes, unknown codes, repeated or full-slot presses and flushes give none.
// From input acceptance to report valid there is one input register, then the
// decode and slot update into the report register.
// One byte is accepted every cycle while the stage moves; the prefix decode, the
// parallel slot compare and the state update all lie between the two registers.
// After reset no keys or modifiers are held and no prefix is pending.
// When the receiver stalls, a waiting report holds in the output register and
// the next byte still enters the input register; further input is then held
// off until the report is taken.
module ps2_scancode_to_hid_report import ps2hid_pkg::*; #(
  parameter int unsigned KEY_SLOTS = DEFAULT_KEY_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ps2hid_in_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ps2hid_out_t out_data_o
);

  logic          in_valid_q;
  ps2hid_in_t    in_q;
  logic          out_valid_q;
  ps2hid_out_t   out_q;
  logic          advance;
  logic          step;
  logic          emit;
  ps2hid_event_t key_event;
  ps2hid_out_t   report;

  // The stage moves when the report register is free or being emptied.
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  ps2hid_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_q),
    .event_o (key_event)
  );

  ps2hid_keys #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_keys (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .event_i  (key_event),
    .emit_o   (emit),
    .report_o (report)
  );

  // Report register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_q <= report;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/ps2hid_decode.sv -----
// Scancode decoder: collects prefix bytes and turns each final code into a key event.
module ps2hid_decode import ps2hid_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  ps2hid_in_t    item_i,
  output ps2hid_event_t event_o
);

  // Prefix state of the first pending code. The second entry of a Pause
  // sequence is always the byte being decoded, so it is not stored.
  logic       ext0_q, ext0_d;
  logic       rel0_q, rel0_d;
  logic [7:0] code0_q, code0_d;
  logic       second_q, second_d;
  logic       pause_q, pause_d;

  // Next prefix state and the event of this byte.
  always_comb begin
    logic [7:0] usage;
    usage    = USAGE_NONE;
    ext0_d   = ext0_q;
    rel0_d   = rel0_q;
    code0_d  = code0_q;
    second_d = second_q;
    pause_d  = pause_q;
    event_o  = '0;

    if (item_i.mode) begin
      // Overflow flush keeps only the Pause prefix flag.
      ext0_d        = 1'b0;
      rel0_d        = 1'b0;
      second_d      = 1'b0;
      event_o.flush = 1'b1;
    end else begin
      case (item_i.scan_byte)
        CODE_SELF_TEST: begin
        end
        CODE_PAUSE_PREFIX: begin
          pause_d = 1'b1;
        end
        CODE_EXTENDED: begin
          if (!second_q) begin
            ext0_d = 1'b1;
          end
        end
        CODE_RELEASE: begin
          if (!second_q) begin
            rel0_d = 1'b1;
          end
        end
        default: begin
          if (!second_q) begin
            code0_d = item_i.scan_byte;
          end
          if (pause_q) begin
            // First code after E1 is held back for the second one.
            second_d = 1'b1;
            pause_d  = 1'b0;
          end else begin
            if (second_q) begin
              if (code0_q == CODE_PAUSE_FIRST && item_i.scan_byte == CODE_PAUSE_SECOND) begin
                usage = USAGE_PAUSE;
              end
            end else if (ext0_q) begin
              usage = extended_usage(item_i.scan_byte);
            end else begin
              usage = base_usage(item_i.scan_byte);
            end
            event_o.key    = (usage != USAGE_NONE);
            event_o.key_up = rel0_q;
            event_o.usage  = usage;
            // The sequence ends here.
            ext0_d   = 1'b0;
            rel0_d   = 1'b0;
            second_d = 1'b0;
          end
        end
      endcase
    end
  end

  // Prefix control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext0_q   <= 1'b0;
      rel0_q   <= 1'b0;
      second_q <= 1'b0;
      pause_q  <= 1'b0;
    end else if (step_i) begin
      ext0_q   <= ext0_d;
      rel0_q   <= rel0_d;
      second_q <= second_d;
      pause_q  <= pause_d;
    end
  end

  // Stored first code of a Pause sequence.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      code0_q <= code0_d;
    end
  end

endmodule

// ----- hdl/ps2hid_keys.sv -----
// Key tracker: holds the modifier byte and the key slots and builds the report.
module ps2hid_keys import ps2hid_pkg::*; #(
  parameter int unsigned KEY_SLOTS = DEFAULT_KEY_SLOTS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  ps2hid_event_t event_i,
  output logic          emit_o,
  output ps2hid_out_t   report_o
);

  logic [7:0] mods_q, mods_d;
  logic [7:0] keys_q [KEY_SLOTS];
  logic [7:0] keys_d [KEY_SLOTS];

  // Slot compare, first-match selection and the update of this event.
  always_comb begin
    logic [7:0]     mod_mask;
    logic           hit_found;
    logic           empty_found;
    logic [KEY_SLOTS-1:0] first_hit;
    logic [KEY_SLOTS-1:0] first_empty;
    logic [7:0]     slots [REPORT_SLOTS];

    mod_mask = '0;
    if (event_i.usage[7:3] == USAGE_MOD_PREFIX) begin
      mod_mask = 8'(1) << event_i.usage[2:0];
    end

    // All slots are compared in parallel; the lowest match wins.
    hit_found   = 1'b0;
    empty_found = 1'b0;
    first_hit   = '0;
    first_empty = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (!hit_found && keys_q[i] == event_i.usage) begin
        first_hit[i] = 1'b1;
        hit_found    = 1'b1;
      end
      if (!empty_found && keys_q[i] == USAGE_NONE) begin
        first_empty[i] = 1'b1;
        empty_found    = 1'b1;
      end
    end

    mods_d = mods_q;
    keys_d = keys_q;
    emit_o = 1'b0;
    if (event_i.flush) begin
      mods_d = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        keys_d[i] = USAGE_NONE;
      end
    end else if (event_i.key) begin
      if (event_i.key_up) begin
        mods_d = mods_q & ~mod_mask;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (first_hit[i]) begin
            keys_d[i] = USAGE_NONE;
          end
        end
        emit_o = hit_found;
      end else if (!hit_found) begin
        // A press already held changes nothing.
        mods_d = mods_q | mod_mask;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (first_empty[i]) begin
            keys_d[i] = event_i.usage;
          end
        end
        emit_o = empty_found;
      end
    end

    // Report carries the first six slots; missing slots read as empty.
    for (int i = 0; i < REPORT_SLOTS; i++) begin
      slots[i] = USAGE_NONE;
      if (i < KEY_SLOTS) begin
        slots[i] = keys_d[i];
      end
    end
    report_o.modifier_bits = mods_d;
    report_o.key_slot_0    = slots[0];
    report_o.key_slot_1    = slots[1];
    report_o.key_slot_2    = slots[2];
    report_o.key_slot_3    = slots[3];
    report_o.key_slot_4    = slots[4];
    report_o.key_slot_5    = slots[5];
  end

  // Held modifiers and key slots.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        keys_q[i] <= USAGE_NONE;
      end
    end else if (step_i) begin
      mods_q <= mods_d;
      keys_q <= keys_d;
    end
  end

endmodule
